[src/hscd_pkg.sv]
package hscd_pkg;

  // Fixed field widths
  localparam int unsigned DEV_W    = 8;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  localparam int unsigned ENTRIES_DEF = 1021;
  localparam int unsigned LINE_SHIFT  = 6;

  localparam logic [HASH_W-1:0] DEV_MUL = 32'd524287;
  localparam logic [HASH_W-1:0] VOL_MUL = 32'd2606459;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_STORE  = 2'd2,
    OP_INVAL  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_REDUCE,
    ST_FOLD,
    ST_COMMIT,
    ST_INVAL,
    ST_INVAL_RESP
  } state_t;

  // One directory slot as held in the tag RAM
  typedef struct packed {
    logic              valid;
    logic              lock;
    logic [DEV_W-1:0]  dev;
    logic [VOL_W-1:0]  vol;
    logic [SEC_W-1:0]  sec;
  } entry_t;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic mul;
    logic reduce;
    logic fold;
    logic commit;
    logic clr_step;
    logic inval_resp;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_inval;
    logic out_free;
    logic clr_last;
  } status_t;

endpackage

[src/hscd_ram.sv]
module hscd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/hscd_ctrl.sv]
module hscd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  hscd_pkg::status_t status,
  output hscd_pkg::cmd_t    cmd,
  output hscd_pkg::state_t  state
);

  hscd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hscd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hscd_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = hscd_pkg::ST_IDLE;
      end
      hscd_pkg::ST_IDLE: begin
        if (status.in_valid) begin
          state_next = status.is_inval ? hscd_pkg::ST_INVAL : hscd_pkg::ST_MUL;
        end
      end
      hscd_pkg::ST_MUL:    state_next = hscd_pkg::ST_REDUCE;
      hscd_pkg::ST_REDUCE: state_next = hscd_pkg::ST_FOLD;
      hscd_pkg::ST_FOLD:   state_next = hscd_pkg::ST_COMMIT;
      hscd_pkg::ST_COMMIT: begin
        if (status.out_free) state_next = hscd_pkg::ST_IDLE;
      end
      hscd_pkg::ST_INVAL: begin
        if (status.clr_last) state_next = hscd_pkg::ST_INVAL_RESP;
      end
      hscd_pkg::ST_INVAL_RESP: begin
        if (status.out_free) state_next = hscd_pkg::ST_IDLE;
      end
      default: state_next = hscd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      hscd_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      hscd_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = status.in_valid;
      end
      hscd_pkg::ST_MUL:        cmd.mul      = 1'b1;
      hscd_pkg::ST_REDUCE:     cmd.reduce   = 1'b1;
      hscd_pkg::ST_FOLD:       cmd.fold     = 1'b1;
      hscd_pkg::ST_COMMIT:     cmd.commit   = status.out_free;
      hscd_pkg::ST_INVAL:      cmd.clr_step = 1'b1;
      hscd_pkg::ST_INVAL_RESP: cmd.inval_resp = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[src/hscd_dp.sv]
module hscd_dp #(
  parameter int unsigned ENTRIES = hscd_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hscd_pkg::cmd_t                      cmd,
  output hscd_pkg::status_t                   status,
  input  logic                                s_tvalid,
  input  logic [hscd_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hscd_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  // floor(2^32 / ENTRIES): quotient estimate is low by at most one
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(ENTRIES);
  localparam logic [hscd_pkg::HASH_W-1:0] RECIP = RECIP64[31:0];
  localparam logic [hscd_pkg::HASH_W-1:0] N32 = 32'(ENTRIES);
  localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam int unsigned ENTRY_W = $bits(hscd_pkg::entry_t);

  logic [hscd_pkg::DEV_W-1:0]  in_dev;
  logic [hscd_pkg::VOL_W-1:0]  in_vol;
  logic [hscd_pkg::SEC_W-1:0]  in_sec;
  logic [hscd_pkg::HASH_W-1:0] hash_next;

  hscd_pkg::opcode_t           op;
  logic [hscd_pkg::DEV_W-1:0]  dev;
  logic [hscd_pkg::VOL_W-1:0]  vol;
  logic [hscd_pkg::SEC_W-1:0]  sec;
  logic [hscd_pkg::HASH_W-1:0] hash;
  logic [hscd_pkg::HASH_W-1:0] quot;
  logic [IDX_W:0]              rem;
  logic [IDX_W-1:0]            slot;
  logic [IDX_W-1:0]            slot_next;
  logic [IDX_W-1:0]            clr_cnt;

  logic [63:0]                 prod;
  logic [hscd_pkg::HASH_W-1:0] qn;
  logic [hscd_pkg::HASH_W-1:0] rem_full;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [ENTRY_W-1:0]          ram_wdata;
  logic [ENTRY_W-1:0]          ram_rdata;
  hscd_pkg::entry_t            rd_entry;
  hscd_pkg::entry_t            new_entry;
  logic                        match;

  logic                        hit_out;
  logic [hscd_pkg::SLOT_W-1:0] slot_out;

  assign in_dev = s_tdata[7:0];
  assign in_vol = s_tdata[15:8];
  assign in_sec = s_tdata[47:16];

  assign hash_next = 32'(in_dev) * hscd_pkg::DEV_MUL
                   + 32'(in_vol) * hscd_pkg::VOL_MUL
                   + (in_sec >> hscd_pkg::LINE_SHIFT);

  assign prod     = 64'(hash) * 64'(RECIP);
  assign qn       = quot * N32;
  assign rem_full = hash - qn;
  assign slot_next = (rem >= N_EXT) ? IDX_W'(rem - N_EXT) : IDX_W'(rem);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op   <= hscd_pkg::opcode_t'(s_tuser);
      dev  <= in_dev;
      vol  <= in_vol;
      sec  <= in_sec;
      hash <= hash_next;
    end
    if (cmd.mul) begin
      quot <= prod[63:32];
    end
    if (cmd.reduce) begin
      rem <= rem_full[IDX_W:0];
    end
    if (cmd.fold) begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= (clr_cnt == LAST_IDX) ? '0 : clr_cnt + 1'b1;
    end
  end

  assign rd_entry = hscd_pkg::entry_t'(ram_rdata);
  assign match = rd_entry.valid && (rd_entry.dev == dev) && (rd_entry.vol == vol)
              && (rd_entry.sec == sec);

  always_comb begin
    new_entry = rd_entry;
    unique case (op)
      hscd_pkg::OP_LOOKUP: begin
        if (match) new_entry.lock = 1'b1;
      end
      hscd_pkg::OP_UNLOCK: begin
        if (match) new_entry.lock = 1'b0;
      end
      hscd_pkg::OP_STORE: begin
        new_entry.valid = 1'b1;
        new_entry.lock  = 1'b0;
        new_entry.dev   = dev;
        new_entry.vol   = vol;
        new_entry.sec   = sec;
      end
      hscd_pkg::OP_INVAL: new_entry = rd_entry;
    endcase
  end

  // Sweep writes an empty slot; otherwise the commit writes the updated slot back
  assign ram_we    = cmd.clr_step | cmd.commit;
  assign ram_waddr = cmd.clr_step ? clr_cnt : slot;
  assign ram_wdata = cmd.clr_step ? '0 : ENTRY_W'(new_entry);

  hscd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.fold),
    .raddr (slot_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit || cmd.inval_resp) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_out  <= match;
      slot_out <= hscd_pkg::SLOT_W'(slot);
    end else if (cmd.inval_resp) begin
      hit_out  <= 1'b0;
      slot_out <= '0;
    end
  end

  assign m_tdata = hscd_pkg::OUT_DATA_W'(slot_out);
  assign m_tuser = hit_out;

  assign status.in_valid = s_tvalid;
  assign status.is_inval = hscd_pkg::opcode_t'(s_tuser) == hscd_pkg::OP_INVAL;
  assign status.out_free = !m_tvalid || m_tready;
  assign status.clr_last = clr_cnt == LAST_IDX;

endmodule

[src/hashed_sector_cache_directory.sv]
// Tag directory of a direct-mapped sector cache. A request is taken in one
// transaction and gives one result: the hashed slot and whether that slot held
// valid, matching tags before the request. Lookup, unlock and store each pass
// from acceptance to the result register through hash, reciprocal multiply,
// remainder, fold and tag RAM read, and write-back, and the next request is
// taken only once the last one is through. Invalidate-all sweeps the tag RAM
// one slot a cycle. After reset the same sweep runs with s_tready low.
// A finished result waits in the output register while the next request is
// accepted; a result that cannot be handed over stalls the following one.
module hashed_sector_cache_directory #(
  parameter int unsigned ENTRIES = hscd_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // device_id[7:0], volume_id[15:8], line_sector[47:16]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // slot_index[9:0], zero[15:10]
  output logic        m_tuser    // hit[0]
);

  hscd_pkg::cmd_t    cmd;
  hscd_pkg::status_t status;
  hscd_pkg::state_t  state;

  hscd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd),
    .state  (state)
  );

  hscd_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  assign s_tready = cmd.in_ready;

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // The clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!s_tready && state == hscd_pkg::ST_CLEAR))
    else $error("requests taken before clearing pass");

  // Reported slot always lies inside the directory
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[9:0]) < 32'(ENTRIES)))
    else $error("slot index out of range");

  // A result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(cmd.commit || cmd.inval_resp))
    else $error("pending result overwritten");

endmodule

[bench/hscd_dir_checker.sv]
`timescale 1ns / 1ps

module hscd_dir_checker
  import hscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // device_id[7:0], volume_id[15:8], line_sector[47:16]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // slot_index[9:0], zero[15:10]
  input  logic        m_tuser,   // hit[0]
  output int          mismatches,
  output int          outstanding,
  output int          hits_seen,
  output int          results_seen
);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } dir_result_t;

  dir_result_t pending_results[$];

  // directory image, kept in step with every accepted request
  bit             dir_valid [ENTRIES_DEF];
  bit             dir_lock  [ENTRIES_DEF];
  bit [DEV_W-1:0] dir_dev   [ENTRIES_DEF];
  bit [VOL_W-1:0] dir_vol   [ENTRIES_DEF];
  bit [SEC_W-1:0] dir_sec   [ENTRIES_DEF];

  function automatic logic [SLOT_W-1:0] hash_slot(logic [DEV_W-1:0] dev,
                                                  logic [VOL_W-1:0] vol,
                                                  logic [SEC_W-1:0] sec);
    logic [HASH_W-1:0] h;
    // sums and products wrap at 32 bits before the modulo
    h = HASH_W'(dev) * DEV_MUL + HASH_W'(vol) * VOL_MUL + (sec >> LINE_SHIFT);
    return SLOT_W'(h % HASH_W'(ENTRIES_DEF));
  endfunction

  function automatic dir_result_t apply_request(opcode_t op, logic [DEV_W-1:0] dev,
                                                logic [VOL_W-1:0] vol,
                                                logic [SEC_W-1:0] sec);
    dir_result_t       r;
    logic [SLOT_W-1:0] s;
    logic              match;
    if (op == OP_INVAL) begin
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        dir_valid[i] = 1'b0;
        dir_lock[i]  = 1'b0;
      end
      r.hit  = 1'b0;
      r.slot = '0;
      return r;
    end
    s = hash_slot(dev, vol, sec);
    match = dir_valid[s] && dir_dev[s] == dev && dir_vol[s] == vol && dir_sec[s] == sec;
    case (op)
      OP_LOOKUP: if (match) dir_lock[s] = 1'b1;
      OP_UNLOCK: if (match) dir_lock[s] = 1'b0;
      OP_STORE: begin
        dir_dev[s]   = dev;
        dir_vol[s]   = vol;
        dir_sec[s]   = sec;
        dir_valid[s] = 1'b1;
        dir_lock[s]  = 1'b0;
      end
    endcase
    r.hit  = match;
    r.slot = s;
    return r;
  endfunction

  always @(posedge clk) begin
    dir_result_t exp;
    if (rst) begin
      pending_results.delete();
    end else begin
      // results first: an item never produces its result on the edge it is taken
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result hit=%0b data=%h", $realtime, m_tuser, m_tdata);
        end else begin
          exp = pending_results.pop_front();
          if (exp.hit) hits_seen++;
          if (m_tuser !== exp.hit || m_tdata !== {{(16 - SLOT_W){1'b0}}, exp.slot}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected hit=%0b slot=%0d, got hit=%0b data=%h",
                       $realtime, exp.hit, exp.slot, m_tuser, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(apply_request(opcode_t'(s_tuser), s_tdata[7:0],
                                                s_tdata[15:8], s_tdata[47:16]));
    end
    outstanding = pending_results.size();
  end

endmodule

[bench/hashed_sector_cache_directory_tb.sv]
`timescale 1ns / 1ps

module hashed_sector_cache_directory_tb;
  import hscd_pkg::*;

  localparam int RANDOM_REQS = 530;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [VOL_W-1:0] vol;
    logic [SEC_W-1:0] sec;
  } sector_key_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  int mismatches, outstanding, hits_seen, results_seen;
  int op_count[4];
  bit steady_tx;
  bit hold_go;
  sector_key_t key_pool[$];

  always #4 clk = ~clk;

  hashed_sector_cache_directory u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  hscd_dir_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .hits_seen    (hits_seen),
    .results_seen (results_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sector_key_t make_key(logic [7:0] dev, logic [7:0] vol, logic [31:0] sec);
    sector_key_t k;
    k.dev = dev;
    k.vol = vol;
    k.sec = sec;
    return k;
  endfunction

  function automatic sector_key_t rand_key();
    sector_key_t k;
    k.dev = 8'($urandom_range(0, 255));
    k.vol = 8'($urandom_range(0, 255));
    k.sec = $urandom;
    case ($urandom_range(0, 7))
      0: k.sec = '0;
      1: k.sec = '1;
      2: k.sec[5:0] = '0;
      3: k.dev = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      4: k.vol = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return k;
  endfunction

  // near neighbour of a stored key: mostly same slot, different tags
  function automatic sector_key_t variant_of(sector_key_t k);
    sector_key_t v;
    v = k;
    case ($urandom_range(0, 3))
      0: v.sec = k.sec + 32'(ENTRIES_DEF << LINE_SHIFT);
      1: v.sec = k.sec ^ 32'($urandom_range(1, 63));
      2: begin
        v.dev = k.dev + 8'd1;
        v.sec = k.sec - (DEV_MUL << LINE_SHIFT);
      end
      default: v.vol = k.vol ^ (8'd1 << $urandom_range(0, 7));
    endcase
    return v;
  endfunction

  task automatic issue(opcode_t op, sector_key_t k);
    int n;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {k.sec, k.vol, k.dev};
    op_count[op]++;
    if (op == OP_STORE) begin
      if (key_pool.size() < 48) key_pool.push_back(k);
      else key_pool[$urandom_range(0, key_pool.size() - 1)] = k;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = gap_cycles(steady_tx);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin
    bit steady_rx;
    int n;
    steady_rx = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go  = 1'b0;
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      if ($urandom_range(0, 15) == 0) steady_rx = !steady_rx;
      n = gap_cycles(steady_rx);
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    sector_key_t ka, kb, kc, kd, klo, khi, kmix, kmix2, k;
    opcode_t op;
    int r;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    ka = make_key(8'h12, 8'h34, 32'h0400_0040);
    kb = ka;
    kb.sec = ka.sec + 32'd1;                                 // unaligned, same slot
    kc = ka;
    kc.sec = ka.sec + 32'(ENTRIES_DEF << LINE_SHIFT);        // same slot, other sector
    kd = ka;
    kd.dev = ka.dev + 8'd1;
    kd.sec = ka.sec - (DEV_MUL << LINE_SHIFT);               // same slot, other device
    klo   = make_key(8'h00, 8'h00, 32'h0000_0000);
    khi   = make_key(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    kmix  = make_key(8'h00, 8'hFF, 32'hFFFF_FFC0);
    kmix2 = make_key(8'hFF, 8'h00, 32'h0000_003F);

    issue(OP_LOOKUP, ka);
    issue(OP_STORE,  ka);
    issue(OP_LOOKUP, ka);
    issue(OP_STORE,  ka);   // store over a matching slot reports a hit
    issue(OP_UNLOCK, ka);
    issue(OP_UNLOCK, kb);
    issue(OP_STORE,  kb);
    issue(OP_LOOKUP, ka);
    issue(OP_LOOKUP, kb);
    issue(OP_LOOKUP, kc);
    issue(OP_LOOKUP, kd);
    issue(OP_STORE,  klo);
    issue(OP_LOOKUP, klo);
    issue(OP_STORE,  khi);
    issue(OP_LOOKUP, khi);
    issue(OP_STORE,  kmix);
    issue(OP_LOOKUP, kmix2);
    issue(OP_INVAL,  khi);
    issue(OP_LOOKUP, kb);
    issue(OP_UNLOCK, khi);
    issue(OP_STORE,  khi);
    issue(OP_LOOKUP, khi);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 60 == 0) steady_tx = ($urandom_range(0, 3) == 0);
      if (i == 80) hold_go = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_INVAL;
        k  = rand_key();
      end else begin
        r = $urandom_range(0, 99);
        if (key_pool.size() == 0 || r < 25) k = rand_key();
        else if (r < 45) k = variant_of(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 40) op = OP_LOOKUP;
        else if (r < 62) op = OP_UNLOCK;
        else op = OP_STORE;
      end
      issue(op, k);
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d lookups, %0d unlocks, %0d stores, %0d invalidates",
             op_count[OP_LOOKUP], op_count[OP_UNLOCK], op_count[OP_STORE], op_count[OP_INVAL]);
    $display("Checked %0d results (%0d hits), %0d mismatches",
             results_seen, hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
